// ----- sv/srt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the sorted record table: field widths,
// command and status codes, the record layout and the cell control word.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int ID_W         = 30;
   localparam int COURSE_W     = 16;
   localparam int SCORE_W      = 8;
   localparam int POS_W        = 6;
   localparam int STATUS_W     = 2;
   localparam int OPCODE_W     = 2;
   localparam int MAX_DEPTH    = 64;
   localparam int DEFAULT_DEPTH = 64;
   localparam int GROUP_W      = 8;
   localparam int NUM_GROUPS   = MAX_DEPTH / GROUP_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_DELETE = 2'd2,
      OP_UPDATE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_COMPARE = 3'd1,
      CELL_INSERT  = 3'd2,
      CELL_DELETE  = 3'd3,
      CELL_UPDATE  = 3'd4
   } cell_op_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [COURSE_W-1:0] course;
      logic [SCORE_W-1:0]  score;
   } record_type;

   // per-cell compare result, latched when a command is taken
   typedef struct packed {
      logic nlt;   // not (occupied and id < key)
      logic nle;   // not (occupied and id <= key)
      logic hit;   // occupied, id and course both match
   } flag_type;

   typedef struct packed {
      cell_op_type      op;
      record_type       rec;
      logic [POS_W-1:0] pos;
      logic [POS_W:0]   count;
   } cell_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] idx;
   } loc_type;

endpackage

// ----- sv/srt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_req_if
// Command channel of the sorted record table: valid/ready and one command.
// ----------------------------------------------------------------------------
interface srt_req_if;
   import srt_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ID_W-1:0]     student_id;
   logic [COURSE_W-1:0] course_code;
   logic [SCORE_W-1:0]  score;

   modport source (output valid, output opcode, output student_id,
                   output course_code, output score, input ready);
   modport sink   (input valid, input opcode, input student_id,
                   input course_code, input score, output ready);
endinterface

// ----- sv/srt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_rsp_if
// Result channel of the sorted record table: valid/ready and one result.
// ----------------------------------------------------------------------------
interface srt_rsp_if;
   import srt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     found_id;
   logic [COURSE_W-1:0] found_course;
   logic [SCORE_W-1:0]  found_score;
   logic [POS_W-1:0]    position;
   logic                last;

   modport source (output valid, output status, output found_id, output found_course,
                   output found_score, output position, output last, input ready);
   modport sink   (input valid, input status, input found_id, input found_course,
                   input found_score, input position, input last, output ready);
endinterface

// ----- sv/srt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_cell
// One slot of the table: holds a record, compares it against the command
// key and shifts records to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module srt_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  srt_pkg::record_type   left_rec,
   input  srt_pkg::record_type   right_rec,
   output srt_pkg::record_type   rec,
   output srt_pkg::flag_type     flags
);
   import srt_pkg::*;

   localparam logic [POS_W-1:0] IDX_C = POS_W'(IDX);

   record_type rec_ff, rec_in;
   flag_type   flags_ff, flags_in;
   logic       occupied;

   assign occupied = {1'b0, IDX_C} < ctrl.count;

   always_comb begin
      rec_in   = rec_ff;
      flags_in = flags_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_COMPARE: begin
            flags_in.nlt = !(occupied && (rec_ff.id < ctrl.rec.id));
            flags_in.nle = !(occupied && (rec_ff.id <= ctrl.rec.id));
            flags_in.hit = occupied && (rec_ff.id == ctrl.rec.id)
                           && (rec_ff.course == ctrl.rec.course);
         end
         CELL_INSERT: begin
            if (IDX_C > ctrl.pos) begin
               rec_in = left_rec;
            end else if (IDX_C == ctrl.pos) begin
               rec_in = ctrl.rec;
            end
         end
         CELL_DELETE: begin
            if (IDX_C >= ctrl.pos) begin
               rec_in = right_rec;
            end
         end
         CELL_UPDATE: begin
            if (IDX_C == ctrl.pos) begin
               rec_in.score = ctrl.rec.score;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff   <= rec_in;
      flags_ff <= flags_in;
   end

   assign rec   = rec_ff;
   assign flags = flags_ff;

endmodule

// ----- sv/srt_locate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_locate
// Two-stage registered priority tree over the cell flags: finds the lower
// bound, the upper bound and the first exact match of the last command.
// ----------------------------------------------------------------------------
module srt_locate #(
   parameter int TABLE_DEPTH = srt_pkg::DEFAULT_DEPTH
) (
   input  logic                clock,
   input  srt_pkg::flag_type   flags [TABLE_DEPTH],
   output srt_pkg::loc_type    lo_loc,
   output srt_pkg::loc_type    hi_loc,
   output srt_pkg::loc_type    hit_loc
);
   import srt_pkg::*;

   function automatic logic [3:0] first_set8(input logic [GROUP_W-1:0] v);
      logic [3:0] r;
      r = '0;
      for (int k = GROUP_W - 1; k >= 0; k--) begin
         if (v[k]) begin
            r = {1'b1, 3'(k)};
         end
      end
      return r;
   endfunction

   logic [MAX_DEPTH-1:0] nlt_vec, nle_vec, hit_vec;
   logic [3:0] nlt_grp_ff [NUM_GROUPS];
   logic [3:0] nle_grp_ff [NUM_GROUPS];
   logic [3:0] hit_grp_ff [NUM_GROUPS];
   loc_type    lo_in, hi_in, hit_in;
   loc_type    lo_ff, hi_ff, hit_ff;

   always_comb begin
      nlt_vec = '0;
      nle_vec = '0;
      hit_vec = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         nlt_vec[i] = flags[i].nlt;
         nle_vec[i] = flags[i].nle;
         hit_vec[i] = flags[i].hit;
      end
   end

   // first stage: priority within each group of eight cells
   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         nlt_grp_ff[g] <= first_set8(nlt_vec[g*GROUP_W +: GROUP_W]);
         nle_grp_ff[g] <= first_set8(nle_vec[g*GROUP_W +: GROUP_W]);
         hit_grp_ff[g] <= first_set8(hit_vec[g*GROUP_W +: GROUP_W]);
      end
   end

   // second stage: first group that has a set bit
   always_comb begin
      lo_in  = '0;
      hi_in  = '0;
      hit_in = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (nlt_grp_ff[g][3]) begin
            lo_in = {1'b1, 3'(g), nlt_grp_ff[g][2:0]};
         end
         if (nle_grp_ff[g][3]) begin
            hi_in = {1'b1, 3'(g), nle_grp_ff[g][2:0]};
         end
         if (hit_grp_ff[g][3]) begin
            hit_in = {1'b1, 3'(g), hit_grp_ff[g][2:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      hit_ff <= hit_in;
   end

   assign lo_loc  = lo_ff;
   assign hi_loc  = hi_ff;
   assign hit_loc = hit_ff;

endmodule

// ----- sv/sorted_record_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table
// Table of (student id, course, score) records kept sorted by id, with
// stable insert, find of every record of an id, delete and score update.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one command per transfer (insert, find, delete, update).
//   rsp_if returns results; every command gives one result with last set,
//   except a successful find, which gives one result per matching record in
//   table order with last set on the final one.
//   The cells compare at the command transfer edge, then come the
//   group priority stage, the merge stage and execute, which registers
//   the result. A successful find registers its first record after
//   execute and streams one further record per cycle through the read
//   mux while the receiver takes them. One command is in work at a time;
//   req_if.ready is high whenever no command is in work and reset is low,
//   even while the last result still waits in the output register.
//   Reset empties the table (count to zero) and drops any pending result;
//   the record cells themselves are not cleared and need no clearing pass.
//   When the receiver stalls, the result is held and the block waits with
//   its table unchanged until that result is taken.
// ----------------------------------------------------------------------------
module sorted_record_table #(
   parameter int TABLE_DEPTH = srt_pkg::DEFAULT_DEPTH
) (
   input  logic   clock,
   input  logic   reset,
   srt_req_if.sink   req_if,
   srt_rsp_if.source rsp_if
);
   import srt_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [POS_W:0] DEPTH_C = (POS_W + 1)'(TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GRP  = 5'b00010,
      S_SEL  = 5'b00100,
      S_EXEC = 5'b01000,
      S_FIND = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   opcode_type       cmd_op_ff;
   record_type       cmd_ff;
   logic [POS_W:0]   count_ff, count_in;
   logic [POS_W:0]   hi_ff, hi_in;
   logic [POS_W-1:0] ptr_ff, ptr_in;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   record_type       rsp_rec_ff;
   logic [POS_W-1:0] rsp_position_ff;
   logic             rsp_last_ff;

   logic             out_load;
   status_type       out_status;
   record_type       out_rec;
   logic [POS_W-1:0] out_position;
   logic             out_last;

   cell_ctrl_type    ctrl;
   record_type       cell_rec [TABLE_DEPTH];
   record_type       left_rec [TABLE_DEPTH];
   record_type       right_rec [TABLE_DEPTH];
   flag_type         cell_flags [TABLE_DEPTH];
   loc_type          lo_loc, hi_loc, hit_loc;

   logic             req_accept;
   logic             rsp_load;
   logic [POS_W:0]   lo_pos, hi_pos;
   logic             find_last;

   // ---- cell chain ----
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_rec[i] = cell_rec[i];
      end else begin : g_left
         assign left_rec[i] = cell_rec[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_end
         assign right_rec[i] = cell_rec[i];
      end else begin : g_right
         assign right_rec[i] = cell_rec[i+1];
      end

      srt_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_rec  (left_rec[i]),
         .right_rec (right_rec[i]),
         .rec       (cell_rec[i]),
         .flags     (cell_flags[i])
      );
   end

   srt_locate #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_locate (
      .clock   (clock),
      .flags   (cell_flags),
      .lo_loc  (lo_loc),
      .hi_loc  (hi_loc),
      .hit_loc (hit_loc)
   );

   // ---- control ----
   assign req_if.ready = (state_ff == S_IDLE) && !reset;
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_load     = !rsp_valid_ff || rsp_if.ready;

   // no cell at or above the bound means every occupied cell is below it
   assign lo_pos    = lo_loc.found ? {1'b0, lo_loc.idx} : count_ff;
   assign hi_pos    = hi_loc.found ? {1'b0, hi_loc.idx} : count_ff;
   assign find_last = (({1'b0, ptr_ff} + 1'b1) == hi_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.rec     = cmd_ff;
      ctrl.pos     = '0;
      ctrl.count   = count_ff;
      out_load     = 1'b0;
      out_status   = ST_OK;
      out_rec      = '0;
      out_position = '0;
      out_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ctrl.op         = CELL_COMPARE;
               ctrl.rec.id     = req_if.student_id;
               ctrl.rec.course = req_if.course_code;
               ctrl.rec.score  = req_if.score;
               state_in        = S_GRP;
            end
         end
         S_GRP: begin
            state_in = S_SEL;
         end
         S_SEL: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (cmd_op_ff)
               OP_INSERT: begin
                  if (rsp_load) begin
                     out_load = 1'b1;
                     state_in = S_IDLE;
                     if (count_ff == DEPTH_C) begin
                        out_status = ST_FULL;
                     end else begin
                        ctrl.op      = CELL_INSERT;
                        ctrl.pos     = hi_pos[POS_W-1:0];
                        count_in     = count_ff + 1'b1;
                        out_position = hi_pos[POS_W-1:0];
                     end
                  end
               end
               OP_FIND: begin
                  if (lo_pos >= hi_pos) begin
                     if (rsp_load) begin
                        out_load   = 1'b1;
                        out_status = ST_NOT_FOUND;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     ptr_in   = lo_pos[POS_W-1:0];
                     hi_in    = hi_pos;
                     state_in = S_FIND;
                  end
               end
               OP_DELETE, OP_UPDATE: begin
                  if (rsp_load) begin
                     out_load = 1'b1;
                     state_in = S_IDLE;
                     if (!hit_loc.found) begin
                        out_status = ST_NOT_FOUND;
                     end else begin
                        ctrl.pos     = hit_loc.idx;
                        out_position = hit_loc.idx;
                        if (cmd_op_ff == OP_DELETE) begin
                           ctrl.op  = CELL_DELETE;
                           count_in = count_ff - 1'b1;
                        end else begin
                           ctrl.op  = CELL_UPDATE;
                        end
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FIND: begin
            if (rsp_load) begin
               out_load     = 1'b1;
               out_rec      = cell_rec[ptr_ff[IW-1:0]];
               out_position = ptr_ff;
               out_last     = find_last;
               ptr_in       = ptr_ff + 1'b1;
               if (find_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      ptr_ff <= ptr_in;
      if (req_accept) begin
         cmd_op_ff     <= opcode_type'(req_if.opcode);
         cmd_ff.id     <= req_if.student_id;
         cmd_ff.course <= req_if.course_code;
         cmd_ff.score  <= req_if.score;
      end
      if (out_load) begin
         rsp_status_ff   <= out_status;
         rsp_rec_ff      <= out_rec;
         rsp_position_ff <= out_position;
         rsp_last_ff     <= out_last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.found_id     = rsp_rec_ff.id;
   assign rsp_if.found_course = rsp_rec_ff.course;
   assign rsp_if.found_score  = rsp_rec_ff.score;
   assign rsp_if.position     = rsp_position_ff;
   assign rsp_if.last         = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("record count above table depth");

   a_find_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> ({1'b0, ptr_ff} < hi_ff))
      else $error("find pointer past end of matching run");

   a_count_only_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> $stable(count_ff))
      else $error("record count changed outside execute step");
`endif

endmodule
